FILE: rtl/core/crmt_pkg.sv
// ----------------------------------------------------------------------------
// crmt_pkg
// shared types and constants of the channel range map table
// ----------------------------------------------------------------------------
package crmt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CntW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2
	} op_e_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_MISS          = 3'd1,
		ST_ID_ORDER      = 3'd2,
		ST_CIRCUIT_ORDER = 3'd3,
		ST_ZERO          = 3'd4,
		ST_SPAN          = 3'd5,
		ST_FULL          = 3'd6
	} status_e_t;

	// request as it travels down the cell chain
	typedef struct packed {
		logic              lookup;    // lookup still searching while status is miss
		logic              wr;        // insert accepted, write at entry cnt
		logic [CntW-1:0]   cnt;       // table fill seen by this request
		logic [31:0]       id;
		logic [31:0]       first_id;
		logic [31:0]       last_id;
		logic [7:0]        unit;
		logic [15:0]       first_circuit;
		status_e_t         status;
		logic [7:0]        found_unit;
		logic [15:0]       found_circuit;
	} tok_t;

endpackage

FILE: rtl/core/crmt_head.sv
// ----------------------------------------------------------------------------
// crmt_head
// checks inserts, keeps the fill count and launches requests into the chain
// ----------------------------------------------------------------------------
module crmt_head (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [1:0]          opcode,
	input  logic [31:0]         lookup_id,
	input  logic [31:0]         first_id,
	input  logic [31:0]         last_id,
	input  logic [7:0]          range_unit,
	input  logic [15:0]         first_circuit,
	input  logic [15:0]         last_circuit,
	output logic                tok_valid,
	output crmt_pkg::tok_t      tok
);

	logic [crmt_pkg::CntW-1:0] count_q;
	logic                      valid_q;
	crmt_pkg::tok_t            tok_q;
	crmt_pkg::tok_t            tok_d;
	crmt_pkg::status_e_t       ins_status;
	logic                      accept;

	assign accept = in_valid && adv;

	always_comb begin
		priority if (first_id > last_id) begin
			ins_status = crmt_pkg::ST_ID_ORDER;
		end else if (first_circuit > last_circuit) begin
			ins_status = crmt_pkg::ST_CIRCUIT_ORDER;
		end else if (range_unit == 8'd0 || first_circuit == 16'd0) begin
			ins_status = crmt_pkg::ST_ZERO;
		end else if ((last_id - first_id) != {16'd0, last_circuit - first_circuit}) begin
			ins_status = crmt_pkg::ST_SPAN;
		end else if (count_q == crmt_pkg::CntW'(crmt_pkg::TABLE_DEPTH)) begin
			ins_status = crmt_pkg::ST_FULL;
		end else begin
			ins_status = crmt_pkg::ST_OK;
		end
	end

	always_comb begin
		tok_d               = '0;
		tok_d.cnt           = count_q;
		tok_d.id            = lookup_id;
		tok_d.first_id      = first_id;
		tok_d.last_id       = last_id;
		tok_d.unit          = range_unit;
		tok_d.first_circuit = first_circuit;
		tok_d.status        = crmt_pkg::ST_OK;
		unique case (crmt_pkg::op_e_t'(opcode))
			crmt_pkg::OP_INSERT: begin
				tok_d.status = ins_status;
				tok_d.wr     = (ins_status == crmt_pkg::ST_OK);
			end
			crmt_pkg::OP_LOOKUP: begin
				tok_d.status = crmt_pkg::ST_MISS;
				tok_d.lookup = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
			if (in_valid) begin
				if (crmt_pkg::op_e_t'(opcode) == crmt_pkg::OP_CLEAR) begin
					count_q <= '0;
				end else if (tok_d.wr) begin
					count_q <= count_q + crmt_pkg::CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q <= tok_d;
		end
	end

	assign tok_valid = valid_q;
	assign tok       = tok_q;

endmodule

FILE: rtl/core/crmt_cell.sv
// ----------------------------------------------------------------------------
// crmt_cell
// one table entry: stores a range and tests each passing request against it
// ----------------------------------------------------------------------------
module crmt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [crmt_pkg::IdxW-1:0]  cell_idx,
	input  logic                       in_valid,
	input  crmt_pkg::tok_t             in_tok,
	output logic                       out_valid,
	output crmt_pkg::tok_t             out_tok
);

	logic [31:0]     first_id_q;
	logic [31:0]     last_id_q;
	logic [7:0]      unit_q;
	logic [15:0]     first_circuit_q;
	logic            valid_q;
	crmt_pkg::tok_t  tok_q;
	crmt_pkg::tok_t  tok_d;
	logic            live;
	logic            hit;
	logic            write;

	// entry holds data only below the fill count that the request carries
	assign live  = crmt_pkg::CntW'(cell_idx) < in_tok.cnt;
	assign hit   = in_tok.lookup && (in_tok.status == crmt_pkg::ST_MISS) && live
		&& (in_tok.id >= first_id_q) && (in_tok.id <= last_id_q);
	assign write = in_valid && adv && in_tok.wr
		&& (in_tok.cnt[crmt_pkg::IdxW-1:0] == cell_idx);

	always_comb begin
		tok_d = in_tok;
		if (hit) begin
			tok_d.status        = crmt_pkg::ST_OK;
			tok_d.found_unit    = unit_q;
			tok_d.found_circuit = first_circuit_q + 16'(in_tok.id - first_id_q);
		end
	end

	always_ff @(posedge clk) begin
		if (write) begin
			first_id_q      <= in_tok.first_id;
			last_id_q       <= in_tok.last_id;
			unit_q          <= in_tok.unit;
			first_circuit_q <= in_tok.first_circuit;
		end
		if (adv && in_valid) begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;

endmodule

FILE: rtl/core/channel_range_map_table_core.sv
// path from request accept to result valid: the check stage in the head, one register
//   per table cell, then the output register
// throughput: one request per cycle; the cell chain moves every request one cell per cycle
// the whole chain holds while the output register is full and not taken
// reset: asynchronous, clears the fill count and all valid flags; the table is empty
// ----------------------------------------------------------------------------
// channel_range_map_table_core
// first-match channel id range table built as a chain of entry cells
// ----------------------------------------------------------------------------
module channel_range_map_table_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// lookup_id, first_id, last_id, range_unit, first_circuit, last_circuit
	input  logic [135:0] s_axis_tdata,
	// opcode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found_unit, found_circuit
	output logic [23:0]  m_axis_tdata,
	// status
	output logic [2:0]   m_axis_tuser
);

	localparam int Depth = crmt_pkg::TABLE_DEPTH;
	localparam int IW    = crmt_pkg::IdxW;

	logic            adv;
	logic            chain_valid [0:Depth];
	crmt_pkg::tok_t  chain_tok   [0:Depth];
	logic            out_valid_q;
	logic [23:0]     out_data_q;
	logic [2:0]      out_status_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	crmt_head u_head (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (s_axis_tvalid),
		.opcode        (s_axis_tuser),
		.lookup_id     (s_axis_tdata[31:0]),
		.first_id      (s_axis_tdata[63:32]),
		.last_id       (s_axis_tdata[95:64]),
		.range_unit    (s_axis_tdata[103:96]),
		.first_circuit (s_axis_tdata[119:104]),
		.last_circuit  (s_axis_tdata[135:120]),
		.tok_valid     (chain_valid[0]),
		.tok           (chain_tok[0])
	);

	for (genvar g = 0; g < Depth; g++) begin : g_cell
		crmt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cell_idx  (IW'(g)),
			.in_valid  (chain_valid[g]),
			.in_tok    (chain_tok[g]),
			.out_valid (chain_valid[g+1]),
			.out_tok   (chain_tok[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_valid[Depth];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && chain_valid[Depth]) begin
			out_status_q <= chain_tok[Depth].status;
			if (chain_tok[Depth].lookup && chain_tok[Depth].status == crmt_pkg::ST_OK) begin
				out_data_q <= {chain_tok[Depth].found_circuit, chain_tok[Depth].found_unit};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

endmodule

FILE: rtl/core/crmt_checker.sv
// ----------------------------------------------------------------------------
// crmt_checker
// port-level checks of the channel range map table
// ----------------------------------------------------------------------------
module crmt_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tready,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [23:0]  m_axis_tdata,
	input  logic [2:0]   m_axis_tuser
);

	// result held until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// an empty output register never blocks a request
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("request blocked with empty output");

	// results with a status other than ok carry zeros
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != crmt_pkg::ST_OK |-> m_axis_tdata == 24'd0)
		else $error("nonzero data on miss or error");

	// a hit always has a nonzero circuit
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[7:0] != 8'd0 |-> m_axis_tdata[23:8] != 16'd0)
		else $error("hit with zero circuit");

	// status never goes past the full code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= 3'(crmt_pkg::ST_FULL))
		else $error("unused status code");

endmodule

bind channel_range_map_table_core crmt_checker u_crmt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
